### hw/rtl/chd_pkg.sv
// Shared types, constants and helpers for the canonical Huffman decoder.
// Used by chd_ctrl, chd_datapath and the top level; depends on nothing.
`default_nettype none

package chd_pkg;

  localparam int NUM_SYMBOLS = 31;
  localparam int NUM_LEVELS  = 16;
  localparam int SYM_W       = 5;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 6;
  localparam int CHILD_W     = POS_W + 1;
  localparam int VALUE_W     = 30;
  localparam int ACC_W       = 29;
  localparam int LENS_LO_W   = 64;
  localparam int LENS_HI_W   = 60;
  localparam int LENS_W      = LENS_LO_W + LENS_HI_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SYM_W-1:0] SYM_LAST   = SYM_W'(NUM_SYMBOLS - 1);
  localparam logic [SYM_W-1:0] LVL_SWEEP_LAST = SYM_W'(NUM_LEVELS - 1);
  localparam logic [LEN_W-1:0] LEVEL_LAST = LEN_W'(NUM_LEVELS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS_HIGH = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_COUNT,
    S_LEVEL,
    S_SORT,
    S_IDLE,
    S_STEP,
    S_LOOKUP,
    S_XBIT,
    S_EMIT
  } chd_state_t;

  // One row per tree level: leaf count of the level, and the leaf count,
  // node count and sorted-table start of the level below it.
  typedef struct packed {
    logic [SYM_W-1:0] lc;
    logic [SYM_W-1:0] lc_nx;
    logic [POS_W-1:0] size_nx;
    logic [SYM_W-1:0] start_nx;
  } chd_row_t;

  typedef struct packed {
    logic clear;
    logic count;
    logic level;
    logic sort;
    logic capture;
    logic step;
    logic lookup;
    logic xbit;
    logic emit;
  } chd_cmd_t;

  typedef struct packed {
    logic sym_end;
    logic lvl_end;
    logic phase;
    logic walk_err;
    logic walk_leaf;
    logic short_sym;
    logic xbit_last;
    logic out_free;
  } chd_status_t;

  function automatic logic [LEN_W-1:0] chd_sym_len(input logic [LENS_W-1:0] lens,
                                                   input logic [SYM_W-1:0] s);
    return lens[{s, 2'b00} +: LEN_W];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/chd_ctrl.sv
// Sequencer for the canonical Huffman decoder: table build passes and bit walk.
// Depends on chd_pkg; drives chd_datapath through command and status structs.
`default_nettype none

module chd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  chd_pkg::chd_status_t      st,
  output chd_pkg::chd_cmd_t         cmd
);
  import chd_pkg::*;

  chd_state_t state_r;
  chd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (st.sym_end) state_nxt = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.level = 1'b1;
        if (st.lvl_end) state_nxt = S_SORT;
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (st.sym_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = st.phase ? S_XBIT : S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (st.walk_err) begin
          state_nxt = S_EMIT;
        end else if (st.walk_leaf) begin
          state_nxt = S_LOOKUP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = st.short_sym ? S_EMIT : S_IDLE;
      end
      S_XBIT: begin
        cmd.xbit  = 1'b1;
        state_nxt = st.xbit_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // Any register write rebuilds the tables; hold off the input word meanwhile
    if (cfg_we) begin
      state_nxt   = S_CLEAR;
      in_ready    = 1'b0;
      cmd.capture = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/chd_datapath.sv
// Datapath of the canonical Huffman decoder: config registers, level table,
// sorted symbol table, walk state, extra-bit collector and output register.
// Depends on chd_pkg; commanded by chd_ctrl.
`default_nettype none

module chd_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [chd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [chd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_code_bit,
  input  wire logic                            out_ready,
  input  chd_pkg::chd_cmd_t                    cmd,
  output chd_pkg::chd_status_t                 st,
  output logic                                 out_valid,
  output logic [chd_pkg::VALUE_W-1:0]          out_decoded_value,
  output logic                                 out_decode_error
);
  import chd_pkg::*;

  // Configuration
  logic [SYM_W-1:0]     sym_count_r;
  logic [LENS_LO_W-1:0] len_lo_r;
  logic [LENS_HI_W-1:0] len_hi_r;
  logic [LENS_W-1:0]    lens;

  // Table build
  logic [SYM_W-1:0] sweep_r;
  logic [SYM_W-1:0] lc_r [NUM_LEVELS];
  logic [SYM_W-1:0] total_r;
  logic [SYM_W-1:0] suf_r;
  logic [SYM_W-1:0] lc_nx_r;
  logic [SYM_W-1:0] start_nx_r;
  logic [POS_W-1:0] size_nx_r;
  logic [POS_W-1:0] size0_r;

  logic [LEN_W-1:0] scan_len;
  logic             scan_used;
  logic [LEN_W-1:0] lvl_d;
  logic [LEN_W-1:0] lc_addr;
  logic [SYM_W-1:0] lc_sel;
  logic [SYM_W-1:0] suf_d;
  logic [POS_W-1:0] size_half;
  logic [POS_W-1:0] size_d;
  logic [SYM_W-1:0] start_d;

  // Memories
  chd_row_t         lvl_mem [NUM_LEVELS];
  chd_row_t         lvl_rd_r;
  logic [SYM_W-1:0] sym_mem [NUM_SYMBOLS];
  logic [SYM_W-1:0] sym_rd_r;

  // Walk state
  logic             bit_r;
  logic             phase_r;
  logic [LEN_W-1:0] lv_r;
  logic [POS_W-1:0] pos_r;
  logic [SYM_W-1:0] rem_r;
  logic [ACC_W-1:0] acc_r;
  logic [SYM_W-1:0] held_r;

  logic               malformed;
  logic               at_leaf;
  logic [POS_W-1:0]   idx;
  logic [CHILD_W-1:0] child;
  logic               miss;
  logic               leaf;
  logic               walk_err;
  logic [SYM_W-1:0]   sym_addr;
  logic [ACC_W-1:0]   acc_nxt;
  logic [SYM_W-1:0]   sh;
  logic [VALUE_W-1:0] lead_one;
  logic [VALUE_W-1:0] low_mask;
  logic [VALUE_W-1:0] xvalue;
  logic               out_free;
  logic               to_root;

  // Result and output registers
  logic [VALUE_W-1:0] res_value_r;
  logic               res_err_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_err_r;

  assign lens = {len_hi_r, len_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_count_r <= '0;
      len_lo_r    <= '0;
      len_hi_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYMBOL_COUNT: sym_count_r <= cfg_wdata[SYM_W-1:0];
        CFG_LENGTHS_LOW:  len_lo_r    <= cfg_wdata[LENS_LO_W-1:0];
        CFG_LENGTHS_HIGH: len_hi_r    <= cfg_wdata[LENS_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- table build ----------------
  always_comb begin
    scan_len  = chd_sym_len(lens, sweep_r);
    scan_used = (sweep_r < sym_count_r) && (scan_len != '0);
    lvl_d     = LEVEL_LAST - sweep_r[LEN_W-1:0];
    lc_addr   = cmd.level ? lvl_d : scan_len;
    lc_sel    = lc_r[lc_addr];
    suf_d     = suf_r + lc_sel;
    size_half = POS_W'((CHILD_W'(size_nx_r) + CHILD_W'(1)) >> 1);
    size_d    = POS_W'(lc_sel) + size_half;
    start_d   = total_r - suf_d;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sweep_r    <= '0;
      total_r    <= '0;
      suf_r      <= '0;
      lc_nx_r    <= '0;
      start_nx_r <= '0;
      size_nx_r  <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lc_r[i] <= '0;
      end
    end else if (cmd.count || cmd.sort) begin
      sweep_r <= (sweep_r == SYM_LAST) ? '0 : sweep_r + SYM_W'(1);
      if (scan_used) begin
        lc_r[scan_len] <= lc_sel + SYM_W'(1);
        if (cmd.count) total_r <= total_r + SYM_W'(1);
      end
    end else if (cmd.level) begin
      sweep_r    <= (sweep_r == LVL_SWEEP_LAST) ? '0 : sweep_r + SYM_W'(1);
      // Counter turns into the placement pointer for the sort pass
      lc_r[lvl_d] <= start_d;
      suf_r      <= suf_d;
      lc_nx_r    <= lc_sel;
      start_nx_r <= start_d;
      size_nx_r  <= size_d;
      size0_r    <= size_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.level) begin
      lvl_mem[lvl_d] <= '{lc: lc_sel, lc_nx: lc_nx_r, size_nx: size_nx_r,
                          start_nx: start_nx_r};
    end
    lvl_rd_r <= lvl_mem[lv_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.sort && scan_used) begin
      sym_mem[lc_sel] <= sweep_r;
    end
    if (cmd.step) begin
      sym_rd_r <= sym_mem[sym_addr];
    end
  end

  // ---------------- walk ----------------
  always_comb begin
    malformed = (size0_r != POS_W'(1));
    at_leaf   = pos_r < POS_W'(lvl_rd_r.lc);
    idx       = pos_r - POS_W'(lvl_rd_r.lc);
    child     = {idx, bit_r};
    miss      = child >= CHILD_W'(lvl_rd_r.size_nx);
    leaf      = child < CHILD_W'(lvl_rd_r.lc_nx);
    walk_err  = malformed || (lv_r == LEVEL_LAST) || at_leaf || miss;
    sym_addr  = lvl_rd_r.start_nx + child[SYM_W-1:0];
    acc_nxt   = {acc_r[ACC_W-2:0], bit_r};
    sh        = held_r - SYM_W'(1);
    lead_one  = VALUE_W'(1) << sh;
    low_mask  = lead_one - VALUE_W'(1);
    xvalue    = lead_one | (VALUE_W'(acc_nxt) & low_mask);
    out_free  = !out_valid_r || out_ready;
    to_root   = cfg_we || (cmd.emit && out_free);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) bit_r <= in_code_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || to_root) begin
      phase_r <= 1'b0;
      lv_r    <= '0;
      pos_r   <= '0;
      rem_r   <= '0;
      acc_r   <= '0;
      held_r  <= '0;
    end else if (cmd.step) begin
      if (!walk_err && !leaf) begin
        lv_r  <= lv_r + LEN_W'(1);
        pos_r <= child[POS_W-1:0];
      end
    end else if (cmd.lookup) begin
      if (sym_rd_r >= SYM_W'(2)) begin
        phase_r <= 1'b1;
        held_r  <= sym_rd_r;
        rem_r   <= sym_rd_r - SYM_W'(1);
        acc_r   <= '0;
        lv_r    <= '0;
        pos_r   <= '0;
      end
    end else if (cmd.xbit) begin
      acc_r <= acc_nxt;
      rem_r <= rem_r - SYM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && walk_err) begin
      res_value_r <= '0;
      res_err_r   <= 1'b1;
    end else if (cmd.lookup) begin
      res_value_r <= VALUE_W'(sym_rd_r);
      res_err_r   <= 1'b0;
    end else if (cmd.xbit) begin
      res_value_r <= xvalue;
      res_err_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_value_r <= res_value_r;
      out_err_r   <= res_err_r;
    end
  end

  always_comb begin
    st.sym_end   = (sweep_r == SYM_LAST);
    st.lvl_end   = (sweep_r == LVL_SWEEP_LAST);
    st.phase     = phase_r;
    st.walk_err  = walk_err;
    st.walk_leaf = leaf;
    st.short_sym = sym_rd_r < SYM_W'(2);
    st.xbit_last = (rem_r == SYM_W'(1));
    st.out_free  = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_value = out_value_r;
  assign out_decode_error  = out_err_r;

  // The count runs out on the last extra bit; the emit step follows with it at zero
  a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r && !cmd.emit) |-> (held_r >= SYM_W'(2)) && (rem_r != '0))
    else $error("extra-bit phase with bad symbol or count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_value_r == '0))
    else $error("error result with nonzero value");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && out_free && !cfg_we) |=> out_valid_r)
    else $error("emitted result not held in output register");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !phase_r |-> (lv_r != LEVEL_LAST))
    else $error("walk reached a level with no children");

endmodule

`default_nettype wire

### hw/rtl/canonical_huffman_decoder_extra_bits.sv
// Top level of the canonical Huffman decoder with extra-bit suffix.
// Depends on chd_pkg, chd_ctrl and chd_datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | input     | in_valid/in_ready  | in_code_bit
//   out     | output    | out_valid/out_ready| out_decoded_value, out_decode_error
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// Steps: a code bit that moves to an internal node takes a level-table read, then a
//   step. A bit that lands on a leaf also takes a symbol-table lookup, plus an emit for
//   symbols 0 and 1. Each extra bit is captured, then collected; the last one adds the emit.
// Table build: after reset and after every register write the block runs a clear step
//   and the count, level and sort passes with in_ready low.
// Stalls: the result sits in an output register; the walk holds in the emit
//   step only while that register is full and out_ready is low.
// Reset: synchronous, active low; the walk restarts at the root.
`default_nettype none

module canonical_huffman_decoder_extra_bits (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [chd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [chd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_code_bit,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [chd_pkg::VALUE_W-1:0]         out_decoded_value,
  output logic                                out_decode_error
);
  import chd_pkg::*;

  chd_cmd_t    cmd;
  chd_status_t st;

  // Sequencer: build passes, then one word at a time through the walk
  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables, walk registers and the output register
  chd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_code_bit       (in_code_bit),
    .out_ready         (out_ready),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_valid),
    .out_decoded_value (out_decoded_value),
    .out_decode_error  (out_decode_error)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for canonical_huffman_decoder_extra_bits: streams code bits over
// valid/ready, reprograms the code table between phases and predicts every decoded word.
// Depends on chd_pkg and the decoder RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chd_pkg::*;

  // Index past the register list; a write there only rebuilds the tables and resets the walk.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam int ITEM_TARGET = 900;
  localparam int SETTLE      = 12;
  localparam int LONG_HOLD   = 400;     // one receiver hold-off, long enough to back up input
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               err;
  } decode_word_t;

  typedef enum {EXTRA_RANDOM, EXTRA_ZEROS, EXTRA_ONES} extra_fill_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_code_bit = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_W-1:0]    out_decoded_value;
  logic                  out_decode_error;

  canonical_huffman_decoder_extra_bits uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_bit       (in_code_bit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_value (out_decoded_value),
    .out_decode_error  (out_decode_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: a copy of the code table and of the walk state.
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0]     cnt_cfg;
  logic [LENS_LO_W-1:0] lens_lo_cfg;
  logic [LENS_HI_W-1:0] lens_hi_cfg;

  int leaf_cnt [0:16];   // used symbols per code length
  int lvl_size [0:16];   // leaves plus internal nodes per tree level
  int code_depth;

  logic              collecting;   // past the leaf, gathering extra bits
  logic [3:0]        cur_level;
  logic [POS_W-1:0]  cur_pos;
  logic [SYM_W-1:0]  extra_left;
  logic [ACC_W-1:0]  extra_acc;
  logic [SYM_W-1:0]  held_sym;

  decode_word_t expected_words[$];

  // Length of symbol s if it takes part in the code, else 0.
  function automatic int code_len(input int s);
    if (s >= NUM_SYMBOLS || s >= cnt_cfg) return 0;
    if (s < 16) return lens_lo_cfg[4*s +: 4];
    return lens_hi_cfg[4*(s-16) +: 4];
  endfunction

  // k-th used symbol of length d, in symbol order.
  function automatic int leaf_symbol(input int d, input int k);
    int s, n;
    n = 0;
    for (s = 0; s < NUM_SYMBOLS; s++) begin
      if (code_len(s) == d) begin
        if (n == k) return s;
        n++;
      end
    end
    return 0;
  endfunction

  function automatic void rebuild_tables();
    int s, d, l;
    code_depth = 1;
    for (d = 0; d <= 16; d++) begin
      leaf_cnt[d] = 0;
      lvl_size[d] = 0;
    end
    for (s = 0; s < NUM_SYMBOLS; s++) begin
      l = code_len(s);
      if (l != 0) leaf_cnt[l]++;
      if (l > code_depth) code_depth = l;
    end
    // Fold bottom-up: each level holds its leaves plus one parent per pair below.
    for (d = code_depth; d >= 0; d--)
      lvl_size[d] = leaf_cnt[d] + (((d < 16) ? lvl_size[d+1] : 0) + 1) / 2;
  endfunction

  function automatic void return_to_root();
    collecting = 1'b0;
    cur_level  = '0;
    cur_pos    = '0;
    extra_left = '0;
    extra_acc  = '0;
    held_sym   = '0;
  endfunction

  function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SYMBOL_COUNT: cnt_cfg = data[SYM_W-1:0];
      CFG_LENGTHS_LOW:  lens_lo_cfg = data;
      CFG_LENGTHS_HIGH: lens_hi_cfg = data[LENS_HI_W-1:0];
      default: ;
    endcase
    // Any write, mapped or not, drops a decode in progress.
    rebuild_tables();
    return_to_root();
  endfunction

  function automatic void post_result(input logic [VALUE_W-1:0] value, input logic err);
    decode_word_t w;
    w.value = value;
    w.err   = err;
    expected_words = {expected_words, w};
    return_to_root();
  endfunction

  function automatic void decode_bit(input logic b);
    int          sh, lc, child, s;
    logic [31:0] top;
    if (collecting) begin
      sh = (held_sym >= 2 && held_sym <= 30) ? held_sym - 1 : 1;
      extra_acc = {extra_acc[ACC_W-2:0], b};
      if (extra_left > 0) extra_left = extra_left - 1;
      if (extra_left == 0) begin
        top = 32'd1 << sh;
        post_result(VALUE_W'(top | ({3'b000, extra_acc} & (top - 1))), 1'b0);
      end
    end else if (lvl_size[0] != 1) begin
      // Table does not close into one root: every walking bit is an error.
      post_result('0, 1'b1);
    end else begin
      lc = leaf_cnt[cur_level];
      if (cur_level >= code_depth || cur_pos < lc) begin
        post_result('0, 1'b1);
      end else begin
        child = 2 * (cur_pos - lc) + b;
        if (child >= lvl_size[cur_level + 1]) begin
          post_result('0, 1'b1);          // missing child
        end else if (child < leaf_cnt[cur_level + 1]) begin
          s = leaf_symbol(cur_level + 1, child);
          if (s < 2) begin
            post_result(VALUE_W'(s), 1'b0);
          end else begin
            return_to_root();
            collecting = 1'b1;
            held_sym   = SYM_W'(s);
            extra_left = SYM_W'(s - 1);
          end
        end else begin
          cur_level = cur_level + 1;
          cur_pos   = POS_W'(child);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake bookkeeping, pacing and the long receiver hold-off.
  // ---------------------------------------------------------------------------
  logic code_bits[$];      // bits waiting for the driver
  int   bits_sent = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   held_cycles = 0;
  logic bit_taken = 1'b0;  // a code bit word moved at the last rising edge
  logic word_taken = 1'b0; // a result word moved at the last rising edge
  logic calm = 1'b0;       // no idling on either side during this phase
  logic hold_req = 1'b0;
  decode_word_t want;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_bit(input logic b);
    code_bits = {code_bits, b};
    bits_sent++;
  endfunction

  // Driver: hold the word until taken, then advance after a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || bit_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (code_bits.size() != 0) begin
        in_valid    <= 1'b1;
        in_code_bit <= code_bits[0];
        code_bits.delete(0);
        tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && held_cycles < LONG_HOLD) begin
      held_cycles++;
      out_ready <= 1'b0;
    end else begin
      if (rx_gap > 0) rx_gap--;
      else if (word_taken || $urandom_range(0, 15) == 0) rx_gap = pick_gap();
      out_ready <= (rx_gap == 0);
    end
  end

  // Monitor: predict from each accepted code bit, check each accepted result word.
  always @(posedge clk) begin
    bit_taken  <= rst_n && in_valid && in_ready;
    word_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready) decode_bit(in_code_bit);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("decoded_value: no word expected, got %0d (decode_error %0b)",
                 out_decoded_value, out_decode_error);
          mismatches++;
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (out_decoded_value !== want.value) begin
            $error("decoded_value: expected %0d, got %0d", want.value, out_decoded_value);
            mismatches++;
          end
          if (out_decode_error !== want.err) begin
            $error("decode_error: expected %0b, got %0b", want.err, out_decode_error);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("canonical_huffman_decoder_extra_bits: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    note_reg_write(idx, data);
  endtask

  // Write all three registers, starting at a random one; unused data bits carry noise.
  task automatic program_table(input int count, input logic [LENS_LO_W-1:0] lo,
                               input logic [LENS_HI_W-1:0] hi, input logic stray);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    int                    first, n;
    idx[0] = CFG_SYMBOL_COUNT;
    val[0] = {$urandom, $urandom};
    val[0][SYM_W-1:0] = count[SYM_W-1:0];
    idx[1] = CFG_LENGTHS_LOW;
    val[1] = lo;
    idx[2] = CFG_LENGTHS_HIGH;
    val[2] = {4'($urandom), hi};
    if (stray) write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    first = $urandom_range(0, 2);
    for (n = 0; n < 3; n++) write_reg(idx[(first + n) % 3], val[(first + n) % 3]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue the code of symbol s under the current table, then its extra bits.
  task automatic send_symbol(input int s, input extra_fill_t fill);
    logic path[$];
    int   lvl, pos, i;
    pos = 0;
    for (i = 0; i < s; i++)
      if (code_len(i) == code_len(s)) pos++;
    // Climb to the root: the parent sits after the leaves of the level above.
    for (lvl = code_len(s); lvl > 0; lvl--) begin
      path.push_front(pos[0]);
      pos = leaf_cnt[lvl-1] + pos / 2;
    end
    foreach (path[j]) queue_bit(path[j]);
    for (i = 0; i < s - 1; i++) begin
      case (fill)
        EXTRA_ONES:  queue_bit(1'b1);
        EXTRA_ZEROS: queue_bit(1'b0);
        default:     queue_bit(1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // Mostly whole symbols with random content, now and then a burst of stray bits.
  task automatic send_traffic(input int nbits);
    int used[$];
    int s, start;
    start = bits_sent;
    for (s = 0; s < NUM_SYMBOLS; s++)
      if (code_len(s) != 0) used = {used, s};
    while (bits_sent - start < nbits) begin
      if (used.size() == 0 || $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) queue_bit(1'($urandom_range(0, 1)));
      end else begin
        s = used[$urandom_range(0, used.size() - 1)];
        // Favor short symbols so that words come often.
        if (s > 12 && $urandom_range(0, 1) == 1) s = used[$urandom_range(0, used.size() - 1)];
        send_symbol(s, EXTRA_RANDOM);
      end
    end
  endtask

  // Wait until every bit is taken and every word checked, then let the block settle.
  task automatic drain();
    while (code_bits.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                   count, kind, nsym, pick, i, j, t, s;
    int                   depths[$];
    int                   order[NUM_SYMBOLS];
    logic [3:0]           plan[NUM_SYMBOLS];
    logic [LENS_LO_W-1:0] lo;
    logic [LENS_HI_W-1:0] hi;

    cnt_cfg     = '0;
    lens_lo_cfg = '0;
    lens_hi_cfg = '0;
    rebuild_tables();
    return_to_root();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table (no symbols, plus an unmapped write): each bit is an error.
    program_table(0, {$urandom, $urandom}, {28'($urandom), $urandom}, 1'b1);
    queue_bit(1'b0);
    queue_bit(1'b1);
    drain();

    // Two one-bit codes: symbols 0 and 1 come out at once.
    program_table(2, 64'h11, '0, 1'b0);
    queue_bit(1'b0);
    queue_bit(1'b1);
    drain();

    // Only symbol 0 is used: the right child of the root is missing.
    program_table(2, 64'h1, '0, 1'b0);
    queue_bit(1'b1);
    queue_bit(1'b0);
    drain();

    // Every symbol at length 15: a chain of single children ten levels deep that then fans out.
    program_table(NUM_SYMBOLS, '1, '1, 1'b0);
    queue_bit(1'b1);
    send_symbol(0, EXTRA_RANDOM);
    drain();

    // Symbol 30 with all-ones and all-zeros suffixes hits both value extremes.
    // Hold the receiver off meanwhile so the block fills and stalls its input.
    program_table(NUM_SYMBOLS, 64'h21, 60'h200000000000000, 1'b0);
    hold_req <= 1'b1;
    send_symbol(30, EXTRA_ONES);
    send_symbol(30, EXTRA_ZEROS);
    send_traffic(120);
    drain();

    while (bits_sent < ITEM_TARGET) begin
      calm <= ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // Complete code: split random leaves until there are nsym of them.
        count = $urandom_range(2, NUM_SYMBOLS);
        nsym  = $urandom_range(2, count);
        depths = {0};
        while (depths.size() < nsym) begin
          pick = $urandom_range(0, depths.size() - 1);
          if (depths[pick] < 15) begin
            depths[pick] = depths[pick] + 1;
            depths = {depths, depths[pick]};
          end
        end
        for (i = 0; i < NUM_SYMBOLS; i++) order[i] = i;
        for (i = count - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        // Symbols past the count get junk lengths that must be ignored.
        for (s = 0; s < NUM_SYMBOLS; s++) plan[s] = (s < count) ? 4'd0 : 4'($urandom);
        for (i = 0; i < nsym; i++) plan[order[i]] = 4'(depths[i]);
        if (kind == 6) plan[order[0]] = 4'd0;   // drop one leaf: incomplete code
        lo = '0;
        hi = '0;
        for (s = 0; s < NUM_SYMBOLS; s++) begin
          if (s < 16) lo[4*s +: 4] = plan[s];
          else hi[4*(s-16) +: 4] = plan[s];
        end
      end else if (kind <= 8) begin
        // Random lengths: mostly oversubscribed, so the table fails to form a root.
        count = $urandom_range(0, NUM_SYMBOLS);
        lo = {$urandom, $urandom};
        hi = {28'($urandom), $urandom};
      end else if ($urandom_range(0, 1) == 1) begin
        count = 0;
        lo = {$urandom, $urandom};
        hi = {28'($urandom), $urandom};
      end else begin
        count = $urandom_range(1, NUM_SYMBOLS);
        lo = '1;
        hi = '1;
      end
      program_table(count, lo, hi, $urandom_range(0, 4) == 0);
      send_traffic((kind == 7 || kind == 8) ? $urandom_range(30, 60) : $urandom_range(40, 140));
      // Leave the walk mid-code now and then; the next write must abort it.
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 6)) queue_bit(1'($urandom_range(0, 1)));
      drain();
    end

    drain();
    if (mismatches == 0) begin
      $display("canonical_huffman_decoder_extra_bits: match");
    end else begin
      $display("canonical_huffman_decoder_extra_bits: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/chd_pkg.sv
hw/rtl/chd_ctrl.sv
hw/rtl/chd_datapath.sv
hw/rtl/canonical_huffman_decoder_extra_bits.sv
bench/tb.sv
